// ===== rtl/reversible_deque_assert.svh =====
// Assertion macros for the deque. Each checks at the rising edge of the given clock
// and is disabled while the given active-low reset is low.
`ifndef REVERSIBLE_DEQUE_ASSERT_SVH
`define REVERSIBLE_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS

`define RDQ_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("deque assertion failed");

`define RDQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

`define RDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`else

`define RDQ_ASSERT(lbl, clk, rst_n, cond)

`define RDQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define RDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rdq_pkg.sv =====
`timescale 1ns / 1ps

package rdq_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;

	localparam logic [2:0] ACT_POP_BACK   = 3'd0;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd1;
	localparam logic [2:0] ACT_REVERSE    = 3'd2;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd3;
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]           action;
		logic signed [DW-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DW-1:0] data;
		logic [1:0]           status;
	} res_t;

	typedef struct packed {
		logic                 we;
		logic [AW-1:0]        waddr;
		logic signed [DW-1:0] wdata;
		logic                 re;
		logic [AW-1:0]        raddr;
	} mem_req_t;

	typedef struct packed {
		logic       valid;
		logic       from_mem;
		logic [1:0] status;
	} pend_t;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	// head plus offset, wrapped once; the sum stays below twice the depth
	function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
		logic [AW:0] s;
		s = {1'b0, h} + (AW+1)'(c);
		return (s >= (AW+1)'(DEPTH)) ? AW'(s - (AW+1)'(DEPTH)) : s[AW-1:0];
	endfunction

endpackage

// ===== rtl/rdq_ram.sv =====
`timescale 1ns / 1ps

module rdq_ram #(
	parameter int DATA_W  = 32,
	parameter int ADDR_W  = 10,
	parameter int ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rdq_ctrl.sv =====
`timescale 1ns / 1ps

module rdq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  rdq_pkg::cmd_t          cmd,
	output rdq_pkg::mem_req_t      mem_req,
	output rdq_pkg::pend_t         pend_s1,
	output logic [rdq_pkg::CW-1:0] fill
);

	logic [rdq_pkg::AW-1:0] head_q, head_d;
	logic [rdq_pkg::CW-1:0] cnt_q, cnt_d;
	logic                   flag_q, flag_d;
	rdq_pkg::pend_t         pend_d;
	logic                   to_back;

	always_comb begin
		head_d        = head_q;
		cnt_d         = cnt_q;
		flag_d        = flag_q;
		mem_req       = '0;
		mem_req.wdata = cmd.value;
		pend_d        = '0;
		// logical end maps to the physical back unless reversed
		to_back = ((cmd.action == rdq_pkg::ACT_POP_BACK) ||
			(cmd.action == rdq_pkg::ACT_PUSH_BACK)) != flag_q;
		if (fire) begin
			case (cmd.action)
				rdq_pkg::ACT_POP_BACK, rdq_pkg::ACT_POP_FRONT: begin
					pend_d.valid = 1'b1;
					if (cnt_q == '0) begin
						pend_d.status = rdq_pkg::ST_EMPTY;
					end else begin
						pend_d.from_mem = 1'b1;
						pend_d.status   = rdq_pkg::ST_OK;
						mem_req.re      = 1'b1;
						cnt_d           = cnt_q - 1'b1;
						if (to_back) begin
							mem_req.raddr = rdq_pkg::idx_add(head_q, cnt_q - 1'b1);
						end else begin
							mem_req.raddr = head_q;
							head_d        = rdq_pkg::idx_inc(head_q);
						end
					end
				end
				rdq_pkg::ACT_REVERSE: begin
					flag_d = !flag_q;
				end
				rdq_pkg::ACT_PUSH_BACK, rdq_pkg::ACT_PUSH_FRONT: begin
					if (cnt_q == rdq_pkg::CW'(rdq_pkg::DEPTH)) begin
						// drop the push and report it
						pend_d.valid  = 1'b1;
						pend_d.status = rdq_pkg::ST_FULL;
					end else begin
						mem_req.we = 1'b1;
						cnt_d      = cnt_q + 1'b1;
						if (to_back) begin
							mem_req.waddr = rdq_pkg::idx_add(head_q, cnt_q);
						end else begin
							head_d        = rdq_pkg::idx_dec(head_q);
							mem_req.waddr = rdq_pkg::idx_dec(head_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			cnt_q   <= '0;
			flag_q  <= 1'b0;
			pend_s1 <= '0;
		end else begin
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			flag_q  <= flag_d;
			pend_s1 <= pend_d;
		end
	end

	assign fill = cnt_q;

endmodule

// ===== rtl/rdq_obuf.sv =====
`timescale 1ns / 1ps

module rdq_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rdq_pkg::res_t push_item,
	input  logic          pop,
	output rdq_pkg::res_t item,
	output logic          valid,
	output logic [1:0]    level
);

	rdq_pkg::res_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			level_q <= level_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign item  = ent_q[rd_q];
	assign valid = (level_q != '0);
	assign level = level_q;

endmodule

// ===== rtl/reversible_deque.sv =====
`timescale 1ns / 1ps
// channel | signals                     | payload
// cmd     | cmd_valid, cmd_ready        | cmd.action, cmd.value
// res     | res_valid, res_ready        | res.data, res.status
//
// The pointer logic handles every action; a pop reads the word store
// through its single read port and its result reaches the output buffer in the next cycle.
// One action per cycle while the two-entry output buffer has room; results drain in order.
// Reset clears the pointers, count, reversal flag and buffer; the word store is not cleared.
// A stalled res channel fills the buffer and then holds cmd_ready low.

module reversible_deque (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  rdq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output rdq_pkg::res_t res
);

	`include "reversible_deque_assert.svh"

	rdq_pkg::mem_req_t          mem_req;
	rdq_pkg::pend_t             pend_s1;
	logic [rdq_pkg::CW-1:0]     fill;
	logic [rdq_pkg::DW-1:0]     rdata;
	rdq_pkg::res_t              land;
	logic [1:0]                 level;
	logic [1:0]                 used;
	logic                       cmd_fire;
	logic                       res_fire;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign res_fire = res_valid && res_ready;

	// count the result in flight against the buffer
	assign used      = level + {1'b0, pend_s1.valid};
	assign cmd_ready = (used - {1'b0, res_fire}) < 2'd2;

	rdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (cmd_fire),
		.cmd     (cmd),
		.mem_req (mem_req),
		.pend_s1 (pend_s1),
		.fill    (fill)
	);

	rdq_ram #(
		.DATA_W  (rdq_pkg::DW),
		.ADDR_W  (rdq_pkg::AW),
		.ENTRIES (rdq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	always_comb begin
		land.data   = pend_s1.from_mem ? rdata : '0;
		land.status = pend_s1.status;
	end

	rdq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pend_s1.valid),
		.push_item (land),
		.pop       (res_fire),
		.item      (res),
		.valid     (res_valid),
		.level     (level)
	);

	`RDQ_ASSERT(a_fill_range, clk, arst_n, fill <= rdq_pkg::CW'(rdq_pkg::DEPTH))
	`RDQ_ASSERT(a_one_port_op, clk, arst_n, !(mem_req.we && mem_req.re))
	`RDQ_ASSERT_NEXT(a_read_lands, clk, arst_n, mem_req.re, pend_s1.valid && pend_s1.from_mem)
	`RDQ_ASSERT_SAME(a_no_overflow, clk, arst_n, pend_s1.valid, (level < 2'd2) || res_fire)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

import rdq_pkg::*;

// Shadow copy of the deque; predicts one reply per pop or dropped push.
class deque_mirror;
	logic [DW-1:0] words [DEPTH];
	int head;
	int fill;
	int peak;
	bit flipped;
	res_t due[$];
	int errors;
	int accepted;
	int pops_ok;
	int pops_empty;
	int drops;
	int flips;

	function void apply_cmd(cmd_t c);
		res_t r;
		bit at_back;
		accepted++;
		r = '0;
		// a logical end maps to the opposite physical end while reversed
		at_back = ((c.action == ACT_POP_BACK) || (c.action == ACT_PUSH_BACK)) != flipped;
		case (c.action)
			ACT_POP_BACK, ACT_POP_FRONT: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
					pops_empty++;
				end else begin
					if (at_back) begin
						r.data = words[(head + fill - 1) % DEPTH];
					end else begin
						r.data = words[head];
						head = (head + 1) % DEPTH;
					end
					fill--;
					r.status = ST_OK;
					pops_ok++;
				end
				due.insert(due.size(), r);
			end
			ACT_REVERSE: begin
				flipped = !flipped;
				flips++;
			end
			ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
					drops++;
					due.insert(due.size(), r);
				end else begin
					if (at_back) begin
						words[(head + fill) % DEPTH] = c.value;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						words[head] = c.value;
					end
					fill++;
					if (fill > peak) peak = fill;
				end
			end
			default: ;
		endcase
	endfunction

	function void check_reply(res_t got);
		res_t want;
		if (due.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected reply: data %0d status %0d", got.data, got.status);
			return;
		end
		want = due[0];
		due.delete(0);
		if (got.data !== want.data || got.status !== want.status) begin
			errors++;
			if (errors <= 10)
				$display("reply mismatch: expected data %0d status %0d, got data %0d status %0d",
					want.data, want.status, got.data, got.status);
		end
	endfunction
endclass

module tb;

	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	res_t res;

	deque_mirror mirror;
	bit steady_send;

	reversible_deque DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly back to back, now and then a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DW-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// push takes whatever weight is left after noise, pops and reversals
	function automatic logic [2:0] pick_action(int pop_w, int rev_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
		if (r < 2 + pop_w) return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
		if (r < 2 + pop_w + rev_w) return ACT_REVERSE;
		return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
	endfunction

	task automatic send_cmd(input logic [2:0] action, input logic [DW-1:0] value);
		cmd_t c;
		int gap;
		c.action = action;
		c.value = value;
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			// scramble the idle payload
			c.action = 3'($urandom());
			c.value = $urandom();
			cmd_valid <= 1'b0;
			cmd <= c;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every pending reply has drained
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (mirror.due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) mirror.apply_cmd(cmd);
			if (res_valid && res_ready) mirror.check_reply(res);
		end
	end

	// receiver: random stalls, one long hold once results are flowing
	initial begin
		int hold;
		int taken;
		int cyc;
		bit long_done;
		bit steady_recv;
		hold = 0;
		taken = 0;
		cyc = 0;
		long_done = 1'b0;
		steady_recv = 1'b0;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (res_valid && res_ready) taken++;
			if (cyc % 64 == 0) steady_recv = ($urandom_range(0, 3) == 0);
			if (taken >= 30 && !long_done) begin
				long_done = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				res_ready <= 1'b0;
				hold--;
			end else begin
				res_ready <= 1'b1;
				if (!steady_recv) hold = pick_gap();
			end
		end
	end

	initial begin
		int n;
		mirror = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		steady_send = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pops, extreme words, both ends, reversal, unused codes
		send_cmd(ACT_POP_BACK, '1);
		send_cmd(ACT_POP_FRONT, 32'h8000_0000);
		send_cmd(ACT_PUSH_BACK, 32'h7fff_ffff);
		send_cmd(ACT_PUSH_FRONT, 32'h8000_0000);
		send_cmd(ACT_PUSH_BACK, '0);
		send_cmd(ACT_PUSH_FRONT, '1);
		send_cmd(ACT_POP_FRONT, 32'h7fff_ffff);
		send_cmd(ACT_REVERSE, '1);
		send_cmd(ACT_POP_FRONT, '0);
		send_cmd(ACT_PUSH_FRONT, 32'h5555_5555);
		send_cmd(ACT_PUSH_BACK, 32'haaaa_aaaa);
		send_cmd(ACT_POP_BACK, 32'h5555_5555);
		send_cmd(ACT_UNUSED_LO, '1);
		send_cmd(3'(ACT_UNUSED_LO + 3'd1), 32'h1234_5678);
		send_cmd(ACT_UNUSED_HI, '0);
		send_cmd(ACT_REVERSE, '0);
		send_cmd(ACT_POP_BACK, $urandom());
		send_cmd(ACT_POP_BACK, $urandom());
		send_cmd(ACT_POP_FRONT, $urandom());
		send_cmd(ACT_POP_FRONT, $urandom());
		send_cmd(ACT_POP_BACK, $urandom());
		send_cmd(ACT_REVERSE, $urandom());
		send_cmd(ACT_PUSH_FRONT, 32'h0000_0001);
		send_cmd(ACT_POP_BACK, $urandom());
		settle();

		// churn around empty, alternating pop-heavy and push-heavy stretches
		for (int i = 0; i < 50; i++) begin
			if (i % 32 == 0) steady_send = ($urandom_range(0, 3) == 0);
			send_cmd(pick_action(((i / 12) % 2) ? 60 : 30, 8), pick_word());
		end
		settle();

		// fill to capacity from both ends so the indices wrap
		n = 0;
		while (mirror.fill < DEPTH) begin
			if (n % 32 == 0) steady_send = ($urandom_range(0, 3) == 0);
			send_cmd(pick_action(1, 1), pick_word());
			n++;
		end

		// hover at full: dropped pushes, pops and reversals
		for (int i = 0; i < 40; i++) begin
			if (i % 16 == 0) steady_send = ($urandom_range(0, 3) == 0);
			send_cmd(pick_action(25, 10), pick_word());
		end
		settle();

		$display("ran %0d commands: %0d pops with data, %0d on empty, %0d pushes dropped",
			mirror.accepted, mirror.pops_ok, mirror.pops_empty, mirror.drops);
		$display("%0d reversals, deepest fill %0d of %0d, %0d mismatches",
			mirror.flips, mirror.peak, DEPTH, mirror.errors);
		if (mirror.errors == 0 && mirror.due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rdq_pkg.sv
rtl/rdq_ram.sv
rtl/rdq_ctrl.sv
rtl/rdq_obuf.sv
rtl/reversible_deque.sv
tb/tb.sv
